// File: src/olme_pkg.sv
package olme_pkg;

  // list geometry
  localparam int MAX_ENTRIES = 64;
  localparam int SLOTS       = MAX_ENTRIES + 2;
  localparam int ENTRY_W     = 7;
  localparam int OP_W        = 3;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_ENTRY_COUNT = '0;

  // operation codes
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_AFTER = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [OP_W-1:0]    op_t;

  // write and read request toward one link memory
  typedef struct packed {
    logic   we;
    entry_t waddr;
    entry_t wdata;
    entry_t raddr;
  } link_req_t;

endpackage

// File: src/ordered_list_move_engine_unit.sv
// busy: front or back moves step FETCH, UNLINK, WA, WB; move after anchor steps FETCH,
//   UNLINK, YREAD, AFTER, LINK; init and readout sweep all n entries; ignored commands
//   finish in the accept cycle; a new command is accepted only once busy falls, paced by
//   the single write port and the registered read of each link memory
// readout: one entry per cycle from a registered output, the receiver cannot stall
// reset (rst_n, synchronous): idle, n = 64, head 1, tail 64; links undefined until init
module ordered_list_move_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  olme_pkg::op_t                        in_operation,
  input  olme_pkg::entry_t                     in_item,
  input  olme_pkg::entry_t                     in_anchor,
  // result channel
  output logic                                 out_valid,
  output olme_pkg::entry_t                     out_entry,
  output logic                                 out_last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [olme_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [olme_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [olme_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import olme_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;  // read both links of the moved entry
  localparam logic [3:0] S_UNLINK = 4'd2;  // splice the entry out of the chain
  localparam logic [3:0] S_WA     = 4'd3;  // first relink write at front or back
  localparam logic [3:0] S_WB     = 4'd4;  // second relink write at front or back
  localparam logic [3:0] S_YREAD  = 4'd5;  // read the anchor's successor after the splice
  localparam logic [3:0] S_AFTER  = 4'd6;  // hook moved entry to that successor
  localparam logic [3:0] S_LINK   = 4'd7;  // hook anchor to moved entry
  localparam logic [3:0] S_INIT   = 4'd8;  // sweep writing the order 1..n
  localparam logic [3:0] S_READ   = 4'd9;  // walk from head, one entry per cycle

  logic [3:0] state_r, state_nxt;
  op_t        op_r, op_nxt;
  entry_t     x_r, x_nxt;
  entry_t     y_r, y_nxt;
  entry_t     cnt_r, cnt_nxt;
  logic       first_r, first_nxt;
  entry_t     head_r, head_nxt;
  entry_t     tail_r, tail_nxt;
  entry_t     count_r;

  logic       out_valid_r, out_valid_nxt;
  entry_t     out_entry_r, out_entry_nxt;
  logic       out_last_r, out_last_nxt;

  link_req_t  nx_req, pv_req;
  entry_t     nx_rdata, pv_rdata;

  entry_t     n_plus1;
  entry_t     n_minus1;
  entry_t     cur;
  entry_t     tail_mid;
  logic       accept;
  logic       x_ok, y_ok;
  logic       cfg_sel;
  logic       cfg_wr;
  entry_t     cfg_val;

  // -------------------------------------------------------------------------
  // configuration register: entry count, clamped into 1..MAX_ENTRIES
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_ENTRY_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {{(CFG_DATA_W-ENTRY_W){1'b0}}, count_r} : '0;

  always_comb begin
    cfg_val = pwdata[ENTRY_W-1:0];
    if (cfg_val == '0) begin
      cfg_val = ENTRY_W'(1);
    end else if (cfg_val > ENTRY_W'(MAX_ENTRIES)) begin
      cfg_val = ENTRY_W'(MAX_ENTRIES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ENTRY_W'(MAX_ENTRIES);
    end else if (cfg_wr) begin
      count_r <= cfg_val;
    end
  end

  // -------------------------------------------------------------------------
  // link memories: successor and predecessor of each entry, with end markers
  // at slot 0 and slot n+1
  // -------------------------------------------------------------------------
  olme_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_req.we),
    .waddr (nx_req.waddr),
    .wdata (nx_req.wdata),
    .raddr (nx_req.raddr),
    .rdata (nx_rdata)
  );

  olme_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (pv_req.we),
    .waddr (pv_req.waddr),
    .wdata (pv_req.wdata),
    .raddr (pv_req.raddr),
    .rdata (pv_rdata)
  );

  // -------------------------------------------------------------------------
  // command decode
  // -------------------------------------------------------------------------
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign n_plus1  = count_r + ENTRY_W'(1);
  assign n_minus1 = count_r - ENTRY_W'(1);
  assign x_ok     = (in_item != '0) && (in_item <= count_r);
  assign y_ok     = (in_anchor != '0) && (in_anchor <= count_r);

  // readout position: head on the first step, then the successor just read
  assign cur = first_r ? head_r : nx_rdata;

  // tail after the moved entry leaves it, before the anchor check
  assign tail_mid = (x_r == tail_r) ? pv_rdata : tail_r;

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = 1'b0;
    out_entry_nxt = out_entry_r;
    out_last_nxt  = out_last_r;

    nx_req.we    = 1'b0;
    nx_req.waddr = x_r;
    nx_req.wdata = x_r;
    nx_req.raddr = x_r;
    pv_req.we    = 1'b0;
    pv_req.waddr = x_r;
    pv_req.wdata = x_r;
    pv_req.raddr = x_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_operation;
          x_nxt  = in_item;
          y_nxt  = in_anchor;
          case (in_operation)
            OP_INIT: begin
              cnt_nxt   = ENTRY_W'(1);
              head_nxt  = ENTRY_W'(1);
              tail_nxt  = count_r;
              state_nxt = S_INIT;
            end
            OP_FRONT: begin
              if (x_ok && (in_item != head_r)) begin
                state_nxt = S_FETCH;
              end
            end
            OP_BACK: begin
              if (x_ok && (in_item != tail_r)) begin
                state_nxt = S_FETCH;
              end
            end
            OP_AFTER: begin
              if (x_ok && y_ok && (in_item != in_anchor)) begin
                state_nxt = S_FETCH;
              end
            end
            OP_READ: begin
              cnt_nxt   = '0;
              first_nxt = 1'b1;
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INIT: begin
        nx_req.we    = 1'b1;
        nx_req.waddr = cnt_r;
        nx_req.wdata = cnt_r + ENTRY_W'(1);
        pv_req.we    = 1'b1;
        pv_req.waddr = cnt_r;
        pv_req.wdata = cnt_r - ENTRY_W'(1);
        if (cnt_r == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ENTRY_W'(1);
        end
      end

      S_FETCH: begin
        nx_req.raddr = x_r;
        pv_req.raddr = x_r;
        state_nxt    = S_UNLINK;
      end

      S_UNLINK: begin
        // p = pv_rdata, q = nx_rdata: next[p] = q, prev[q] = p
        nx_req.we    = 1'b1;
        nx_req.waddr = pv_rdata;
        nx_req.wdata = nx_rdata;
        pv_req.we    = 1'b1;
        pv_req.waddr = nx_rdata;
        pv_req.wdata = pv_rdata;
        case (op_r)
          OP_FRONT: begin
            if (x_r == tail_r) begin
              tail_nxt = pv_rdata;
            end
            state_nxt = S_WA;
          end
          OP_BACK: begin
            if (x_r == head_r) begin
              head_nxt = nx_rdata;
            end
            state_nxt = S_WA;
          end
          default: begin
            // move after anchor; a tail that was the anchor hands over to the item
            if (x_r == head_r) begin
              head_nxt = nx_rdata;
            end
            tail_nxt  = (y_r == tail_mid) ? x_r : tail_mid;
            state_nxt = S_YREAD;
          end
        endcase
      end

      S_WA: begin
        if (op_r == OP_FRONT) begin
          nx_req.we    = 1'b1;
          nx_req.waddr = x_r;
          nx_req.wdata = head_r;
          pv_req.we    = 1'b1;
          pv_req.waddr = head_r;
          pv_req.wdata = x_r;
        end else begin
          nx_req.we    = 1'b1;
          nx_req.waddr = tail_r;
          nx_req.wdata = x_r;
          pv_req.we    = 1'b1;
          pv_req.waddr = x_r;
          pv_req.wdata = tail_r;
        end
        state_nxt = S_WB;
      end

      S_WB: begin
        if (op_r == OP_FRONT) begin
          pv_req.we    = 1'b1;
          pv_req.waddr = x_r;
          pv_req.wdata = '0;
          head_nxt     = x_r;
        end else begin
          nx_req.we    = 1'b1;
          nx_req.waddr = x_r;
          nx_req.wdata = n_plus1;
          tail_nxt     = x_r;
        end
        state_nxt = S_IDLE;
      end

      S_YREAD: begin
        nx_req.raddr = y_r;
        state_nxt    = S_AFTER;
      end

      S_AFTER: begin
        // nx_rdata is the anchor's successor once the item is spliced out
        nx_req.we    = 1'b1;
        nx_req.waddr = x_r;
        nx_req.wdata = nx_rdata;
        pv_req.we    = 1'b1;
        pv_req.waddr = nx_rdata;
        pv_req.wdata = x_r;
        state_nxt    = S_LINK;
      end

      S_LINK: begin
        nx_req.we    = 1'b1;
        nx_req.waddr = y_r;
        nx_req.wdata = x_r;
        pv_req.we    = 1'b1;
        pv_req.waddr = x_r;
        pv_req.wdata = y_r;
        state_nxt    = S_IDLE;
      end

      S_READ: begin
        // read the successor of the current entry while it goes out
        nx_req.raddr  = cur;
        first_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        out_entry_nxt = cur;
        out_last_nxt  = (cnt_r == n_minus1);
        if (cnt_r == n_minus1) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ENTRY_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= ENTRY_W'(1);
      tail_r      <= ENTRY_W'(MAX_ENTRIES);
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // command payload and result payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  // each result transfer lasts exactly one cycle
  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_last  = out_last_r;

endmodule

// File: src/olme_ram.sv
module olme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tb_ordered_list_move_engine_unit.sv
`timescale 1ns / 1ps

module tb_ordered_list_move_engine_unit;
  import olme_pkg::*;

  // spare operation codes, all of them must be dropped without results
  localparam op_t OP_RSVD5 = 3'd5;
  localparam op_t OP_RSVD6 = 3'd6;
  localparam op_t OP_RSVD7 = 3'd7;

  // byte address of the entry count register
  localparam logic [CFG_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

  localparam int SIZE_PHASES      = 9;
  localparam int ITEMS_PER_PHASE  = 17;
  localparam int SETTLE_CYCLES    = 70;  // longer than an init or readout walk
  localparam int DIRECTED_COUNT   = 25;

  // one readout entry as the result channel carries it
  typedef struct packed {
    entry_t entry;
    logic   last;
  } readout_word_t;

  // directed row: want_first nonzero means the head of that readout is typed in
  typedef struct packed {
    op_t    op;
    entry_t item;
    entry_t anchor;
    entry_t want_first;
  } directed_row_t;

  // list starts at 64 entries out of reset
  localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    '{OP_INIT,  7'd127, 7'd127, 7'd0},  // build 1..64, unused fields all ones
    '{OP_READ,  7'd0,   7'd0,   7'd1},  // fresh order starts at 1
    '{OP_FRONT, 7'd64,  7'd0,   7'd0},  // tail to front
    '{OP_READ,  7'd0,   7'd0,   7'd64},
    '{OP_BACK,  7'd64,  7'd0,   7'd0},  // head to back
    '{OP_READ,  7'd0,   7'd0,   7'd1},
    '{OP_FRONT, 7'd1,   7'd0,   7'd0},  // head to front: dropped
    '{OP_BACK,  7'd64,  7'd0,   7'd0},  // tail to back: dropped
    '{OP_AFTER, 7'd1,   7'd64,  7'd0},  // head behind the tail, item becomes tail
    '{OP_READ,  7'd0,   7'd0,   7'd2},
    '{OP_AFTER, 7'd5,   7'd5,   7'd0},  // item equals anchor: dropped
    '{OP_FRONT, 7'd0,   7'd0,   7'd0},  // item below range
    '{OP_BACK,  7'd127, 7'd0,   7'd0},  // item above range
    '{OP_AFTER, 7'd3,   7'd0,   7'd0},  // anchor below range
    '{OP_AFTER, 7'd3,   7'd65,  7'd0},  // anchor just above range
    '{OP_RSVD5, 7'd10,  7'd20,  7'd0},
    '{OP_RSVD6, 7'd1,   7'd2,   7'd0},
    '{OP_RSVD7, 7'd127, 7'd127, 7'd0},
    '{OP_AFTER, 7'd1,   7'd3,   7'd0},  // tail moved inside, tail falls back
    '{OP_AFTER, 7'd2,   7'd64,  7'd0},  // head behind the tail
    '{OP_READ,  7'd0,   7'd0,   7'd3},
    '{OP_BACK,  7'd3,   7'd0,   7'd0},  // head to back
    '{OP_READ,  7'd0,   7'd0,   7'd1},
    '{OP_INIT,  7'd0,   7'd0,   7'd0},
    '{OP_READ,  7'd0,   7'd0,   7'd1}
  };

  // sender idle percentage per phase: none, heavy, light
  localparam int IDLE_PCTS [0:2] = '{0, 84, 27};

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  op_t                   in_operation;
  entry_t                in_item;
  entry_t                in_anchor;
  logic                  out_valid;
  entry_t                out_entry;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ordered_list_move_engine_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_item      (in_item),
    .in_anchor    (in_anchor),
    .out_valid    (out_valid),
    .out_entry    (out_entry),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------
  // shadow copy of the list: links, ends and the live entry count
  // ---------------------------------------------------------------
  entry_t link_next [0:SLOTS-1];
  entry_t link_prev [0:SLOTS-1];
  bit     next_known [0:SLOTS-1];  // link written at least once since reset
  entry_t list_head;
  entry_t list_tail;
  int     entry_count_q;

  // readout entries still owed by the block, oldest first
  readout_word_t pending_order [$];

  int sender_idle_pct;
  int errors;
  int commands_sent;
  int readouts_sent;
  int results_checked;
  readout_word_t oldest_want;

  // any link value outside the store points at the front end marker
  function automatic entry_t to_slot(entry_t v);
    return (int'(v) < SLOTS) ? v : entry_t'(0);
  endfunction

  function automatic void set_next(entry_t idx, entry_t val);
    link_next[idx] = val;
    next_known[idx] = 1'b1;
  endfunction

  function automatic void set_prev(entry_t idx, entry_t val);
    link_prev[idx] = val;
  endfunction

  // close the gap left by x
  function automatic void unlink_entry(entry_t x);
    entry_t p;
    entry_t q;
    p = to_slot(link_prev[x]);
    q = to_slot(link_next[x]);
    set_next(p, q);
    set_prev(q, p);
  endfunction

  // a readout must never follow a link that nothing has written yet
  function automatic bit walk_is_safe();
    entry_t now;
    now = to_slot(list_head);
    for (int i = 0; i < entry_count_q - 1; i++) begin
      if (!next_known[now]) return 1'b0;
      now = to_slot(link_next[now]);
    end
    return 1'b1;
  endfunction

  // updates the shadow list for one accepted command, queues readout entries
  function automatic void apply_list_command(op_t op, entry_t x, entry_t y);
    int     n;
    bit     x_ok;
    bit     y_ok;
    entry_t h;
    entry_t t;
    entry_t after;
    entry_t now;
    n = entry_count_q;
    x_ok = (x >= 1) && (int'(x) <= n);
    y_ok = (y >= 1) && (int'(y) <= n);
    case (op)
      OP_INIT: begin
        for (int i = 1; i <= n; i++) begin
          set_prev(entry_t'(i), entry_t'(i - 1));
          set_next(entry_t'(i), entry_t'(i + 1));
        end
        list_head = entry_t'(1);
        list_tail = entry_t'(n);
      end
      OP_FRONT: begin
        if (x_ok && x != list_head) begin
          if (x == list_tail) list_tail = to_slot(link_prev[x]);
          unlink_entry(x);
          h = to_slot(list_head);
          set_prev(h, x);
          set_prev(x, entry_t'(0));
          set_next(x, h);
          list_head = x;
        end
      end
      OP_BACK: begin
        if (x_ok && x != list_tail) begin
          if (x == list_head) list_head = to_slot(link_next[x]);
          unlink_entry(x);
          t = to_slot(list_tail);
          set_next(t, x);
          set_prev(x, t);
          set_next(x, entry_t'(n + 1));
          list_tail = x;
        end
      end
      OP_AFTER: begin
        if (x_ok && y_ok && x != y) begin
          if (x == list_head) list_head = to_slot(link_next[x]);
          if (x == list_tail) list_tail = to_slot(link_prev[x]);
          if (y == list_tail) list_tail = x;
          unlink_entry(x);
          after = to_slot(link_next[y]);
          set_next(x, after);
          set_prev(after, x);
          set_prev(x, y);
          set_next(y, x);
        end
      end
      OP_READ: begin
        now = to_slot(list_head);
        for (int i = 0; i < n; i++) begin
          pending_order.push_back('{entry: now, last: (i == n - 1)});
          now = to_slot(link_next[now]);
        end
      end
      default: ;  // spare codes do nothing
    endcase
  endfunction

  // ---------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // ---------------------------------------------------------------

  // one command transfer; returns at the rising edge that accepted it
  task automatic issue_command(op_t op, entry_t x, entry_t y, entry_t want_first);
    int            base;
    readout_word_t first;
    @(negedge clk);
    // sender gaps carry random junk on the fields
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start        <= 1'b0;
      in_operation <= op_t'($urandom);
      in_item      <= entry_t'($urandom);
      in_anchor    <= entry_t'($urandom);
      @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_item      <= x;
    in_anchor    <= y;
    do @(posedge clk); while (busy);
    base = pending_order.size();
    apply_list_command(op, x, y);
    commands_sent++;
    if (op == OP_READ) readouts_sent++;
    // typed head overrides the shadow list for this readout
    if (want_first != '0 && pending_order.size() > base) begin
      first = pending_order[base];
      first.entry = want_first;
      pending_order[base] = first;
    end
  endtask

  // hold off until every owed entry has come and the block is idle
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_order.size() != 0 || busy) @(negedge clk);
  endtask

  // setup then access phase; register lands at the edge with pready high
  task automatic write_entry_count(logic [CFG_DATA_W-1:0] value);
    int v;
    @(negedge clk);
    start   <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRY_COUNT_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the low 7 bits count, clamped into 1..MAX_ENTRIES
    v = int'(value[ENTRY_W-1:0]);
    if (v < 1) v = 1;
    if (v > MAX_ENTRIES) v = MAX_ENTRIES;
    entry_count_q = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------
  // result checker: sampled at the rising edge, no back-pressure
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_order.size() == 0) begin
        $display("%0t: unexpected result entry %0d last %0b", $time, out_entry, out_last);
        errors++;
      end else begin
        oldest_want = pending_order.pop_front();
        results_checked++;
        if (out_entry !== oldest_want.entry) begin
          $display("%0t: entry mismatch expected %0d actual %0d",
                   $time, oldest_want.entry, out_entry);
          errors++;
        end
        if (out_last !== oldest_want.last) begin
          $display("%0t: last mismatch expected %0b actual %0b",
                   $time, oldest_want.last, out_last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] size_settings [0:SIZE_PHASES-1];
    op_t    op;
    entry_t x;
    entry_t y;
    int     r;

    // includes zero, above range and stray upper bits
    size_settings = '{32'd5, 32'd64, 32'd0, 32'd2, 32'd100, 32'h0000_0183,
                      32'd127, 32'd1, 32'd0};
    size_settings[SIZE_PHASES-1] = $urandom_range(3, 63);

    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_INIT;
    in_item      = '0;
    in_anchor    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    errors          = 0;
    commands_sent   = 0;
    readouts_sent   = 0;
    results_checked = 0;
    sender_idle_pct = 0;

    // shadow reset: 64 entries, head 1, no link written yet
    entry_count_q = MAX_ENTRIES;
    list_head     = entry_t'(1);
    list_tail     = entry_t'(MAX_ENTRIES);
    for (int i = 0; i < SLOTS; i++) begin
      link_next[i]  = '0;
      link_prev[i]  = '0;
      next_known[i] = 1'b0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: first row is the init that makes the links valid
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].want_first != '0) drain_results();
      issue_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].item,
                    DIRECTED_ROWS[i].anchor, DIRECTED_ROWS[i].want_first);
    end

    // random part, one list size per phase
    for (int ph = 0; ph < SIZE_PHASES; ph++) begin
      // block idle and quiet before touching the register
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_entry_count(size_settings[ph]);
      sender_idle_pct = IDLE_PCTS[ph % 3];

      // half the phases keep the old links across the size change
      if ($urandom_range(1) == 1)
        issue_command(OP_INIT, entry_t'($urandom), entry_t'($urandom), '0);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // now and then let everything settle before going on
        if ($urandom_range(24) == 0) drain_results();

        r = $urandom_range(99);
        if (r < 6)       op = OP_INIT;
        else if (r < 30) op = OP_FRONT;
        else if (r < 50) op = OP_BACK;
        else if (r < 80) op = OP_AFTER;
        else if (r < 95) op = OP_READ;
        else             op = op_t'(OP_RSVD5 + op_t'($urandom_range(0, 2)));

        // items lean on the list ends, with some out of range
        r = $urandom_range(99);
        if (r < 10)      x = list_head;
        else if (r < 20) x = list_tail;
        else if (r < 85) x = entry_t'($urandom_range(1, entry_count_q));
        else             x = entry_t'($urandom_range(0, 127));

        r = $urandom_range(99);
        if (r < 12)      y = x;
        else if (r < 22) y = list_tail;
        else if (r < 88) y = entry_t'($urandom_range(1, entry_count_q));
        else             y = entry_t'($urandom_range(0, 127));

        // a walk off into never-written links is replaced by a rebuild
        if (op == OP_READ && !walk_is_safe()) op = OP_INIT;

        issue_command(op, x, y, '0);
      end
    end

    // wind down: all entries in, then a readout's worth of quiet cycles
    drain_results();
    repeat (SETTLE_CYCLES + 10) @(posedge clk);
    if (pending_order.size() != 0) begin
      $display("%0t: %0d readout entries never arrived", $time, pending_order.size());
      errors++;
    end

    $display("summary: %0d commands incl. %0d readouts over %0d list sizes",
             commands_sent, readouts_sent, SIZE_PHASES + 1);
    $display("summary: %0d readout entries compared, %0d mismatches",
             results_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("%0t: timeout, run did not finish", $time);
    $display("status: fail");
    $finish;
  end

endmodule
